[hw/rtl/ucb1_pkg.sv]
// ----------------------------------------------------------------------------
// ucb1_pkg
// Types and constants shared by the UCB1 arm selector modules.
// ----------------------------------------------------------------------------
package ucb1_pkg;

    // Fraction bits of scores and of the logarithm.
    localparam int unsigned FRAC_BITS = 16;
    // Fraction bits of the exploration gain (Q2.14).
    localparam int unsigned GAIN_FRAC = 14;

    localparam logic [15:0] GAIN_RESET = 16'd23167;
    // ln(2) in Q0.32.
    localparam logic [31:0] LN2_Q32    = 32'd2977044472;

    // Width of the shared subtract and compare unit.
    localparam int unsigned SUB_W = 34;

    // Last step indices of the iterative operations.
    localparam logic [5:0] LOG_LAST  = 6'd15;
    localparam logic [5:0] EXP_LAST  = 6'd47;
    localparam logic [5:0] RAD_LAST  = 6'd39;
    localparam logic [5:0] SQRT_LAST = 6'd19;

    // Saturation limit of the exploitation term, 65535 in Q16.16.
    localparam logic [47:0] EXPLOIT_CAP = 48'hFFFF_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INC,
        S_NORM,
        S_SQ_MUL,
        S_SQ_ADJ,
        S_LN,
        S_ARM,
        S_DIV_EXP,
        S_DIV_RAD,
        S_SQRT,
        S_EXPL,
        S_SCORE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [SUB_W-1:0] diff;
        logic             ge;
    } t_sub_res;

endpackage

[hw/rtl/ucb1_sub_unit.sv]
// ----------------------------------------------------------------------------
// ucb1_sub_unit
// Shared trial subtractor used by the division and square root steps.
// ----------------------------------------------------------------------------
module ucb1_sub_unit (
    input  logic [ucb1_pkg::SUB_W-1:0] i_a,
    input  logic [ucb1_pkg::SUB_W-1:0] i_b,
    output ucb1_pkg::t_sub_res         o_res
);
    import ucb1_pkg::*;

    logic [SUB_W:0] w_full;

    // The extra top bit is the borrow: clear means a >= b.
    assign w_full     = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.diff = w_full[SUB_W-1:0];
    assign o_res.ge   = ~w_full[SUB_W];

endmodule

[hw/rtl/ucb1_arm_selector_core.sv]
// ----------------------------------------------------------------------------
// ucb1_arm_selector_core
// UCB1 arm selection over a run of arm items with an iterative datapath.
// ----------------------------------------------------------------------------
// Usage:
// Arm items enter on the input channel (i_in_valid / o_in_stall). A run is a
// sequence of items closed by one with i_last_arm set; that item produces one
// result on the output channel (o_out_valid / i_out_stall) carrying the index
// of the best scoring valid arm and a found flag.
// The first item of a run first bumps the selection total and computes the
// natural log of the new total plus one: a normalize loop, then 16 squaring
// steps, each a multiply and an adjust. A valid arm then keeps the input
// stalled through a 48-step and a 40-step restoring division and a 20-step
// square root, all on one shared subtractor, then a gain multiply and the
// compare. Invalid items, and items past MAX_ARMS, skip these steps.
// The result sits in an output register; the block keeps taking items while
// it waits, and holds only at the end of the next run if it is still unread.
// Reset (synchronous, active low) clears the total, ends any open run, drops
// a pending result and restores the gain to its default. The configuration
// channel writes the gain at any cycle with i_cfg_valid; it is always ready.
// ----------------------------------------------------------------------------
module ucb1_arm_selector_core #(
    parameter int unsigned MAX_ARMS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_success_count,
    input  logic [31:0] i_pull_count,
    input  logic        i_arm_valid,
    input  logic        i_last_arm,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [9:0]  o_pick_index,
    output logic        o_found,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import ucb1_pkg::*;

    localparam int unsigned PW = $clog2(MAX_ARMS + 1);

    t_state r_state, n_state;

    logic [5:0]  r_cnt;
    logic [31:0] r_total;
    logic        r_in_run;
    logic [23:0] r_log;
    logic [PW-1:0] r_pos;
    logic [31:0] r_best_score;
    logic [9:0]  r_best_arm;
    logic        r_found;
    logic [15:0] r_gain;
    logic        r_out_valid;
    logic [9:0]  r_out_index;
    logic        r_out_found;

    logic [31:0] r_succ;
    logic [31:0] r_pulls;
    logic        r_valid;
    logic        r_last;
    logic [47:0] r_dq;
    logic [SUB_W-1:0] r_rem;
    logic [32:0] r_den;
    logic [31:0] r_exploit;
    logic [19:0] r_root;
    logic [32:0] r_x;
    logic [5:0]  r_n;
    logic [31:0] r_m;
    logic [63:0] r_prod;
    logic [15:0] r_frac;
    logic [21:0] r_explore;

    logic        w_in_acc;
    logic        w_out_free;
    logic        w_arm_ok;
    logic [SUB_W-1:0] w_sub_a;
    logic [SUB_W-1:0] w_sub_b;
    t_sub_res    w_sub;
    logic [47:0] w_quot;
    logic [32:0] w_sq_top;
    logic [21:0] w_lres;
    logic [53:0] w_ln_prod;
    logic [35:0] w_gain_prod;
    logic [32:0] w_sum;
    logic [31:0] w_score;
    logic [31:0] w_exploit;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_pick_index = r_out_index;
    assign o_found     = r_out_found;

    assign w_in_acc   = i_in_valid & ~o_in_stall;
    assign w_out_free = ~r_out_valid | ~i_out_stall;
    assign w_arm_ok   = r_valid & (r_pos < MAX_ARMS);

    // Division shifts one dividend bit in; the square root shifts two.
    always_comb begin
        if (r_state == S_SQRT) begin
            w_sub_a = {r_rem[SUB_W-3:0], r_dq[47:46]};
            w_sub_b = {12'd0, r_root, 2'b01};
        end else begin
            w_sub_a = {r_rem[SUB_W-2:0], r_dq[47]};
            w_sub_b = {1'b0, r_den};
        end
    end

    ucb1_sub_unit u_sub (
        .i_a   (w_sub_a),
        .i_b   (w_sub_b),
        .o_res (w_sub)
    );

    assign w_quot      = {r_dq[46:0], w_sub.ge};
    assign w_exploit   = (w_quot > EXPLOIT_CAP) ? EXPLOIT_CAP[31:0] : w_quot[31:0];
    assign w_sq_top    = r_prod[63:31];
    assign w_lres      = {r_n, r_frac};
    assign w_ln_prod   = 54'(w_lres) * 54'(LN2_Q32);
    assign w_gain_prod = 36'(r_gain) * 36'(r_root);
    assign w_sum       = {1'b0, r_exploit} + {11'd0, r_explore};
    assign w_score     = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = r_in_run ? S_ARM : S_INC;
                end
            end
            S_INC:    n_state = S_NORM;
            S_NORM: begin
                if (r_x[32]) begin
                    n_state = S_SQ_MUL;
                end
            end
            S_SQ_MUL: n_state = S_SQ_ADJ;
            S_SQ_ADJ: n_state = (r_cnt == LOG_LAST) ? S_LN : S_SQ_MUL;
            S_LN:     n_state = S_ARM;
            S_ARM:    n_state = w_arm_ok ? S_DIV_EXP : S_DONE;
            S_DIV_EXP: begin
                if (r_cnt == EXP_LAST) begin
                    n_state = S_DIV_RAD;
                end
            end
            S_DIV_RAD: begin
                if (r_cnt == RAD_LAST) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_cnt == SQRT_LAST) begin
                    n_state = S_EXPL;
                end
            end
            S_EXPL:   n_state = S_SCORE;
            S_SCORE:  n_state = S_DONE;
            S_DONE: begin
                if (!r_last || w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control and run state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total      <= '0;
            r_in_run     <= 1'b0;
            r_log        <= '0;
            r_pos        <= '0;
            r_best_score <= '0;
            r_best_arm   <= '0;
            r_found      <= 1'b0;
            r_gain       <= GAIN_RESET;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_gain <= i_cfg_data;
            end
            if (r_state == S_DONE && r_last && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INC: begin
                    if (r_total != 32'hFFFF_FFFF) begin
                        r_total <= r_total + 32'd1;
                    end
                    r_in_run     <= 1'b1;
                    r_pos        <= '0;
                    r_best_score <= '0;
                    r_best_arm   <= '0;
                    r_found      <= 1'b0;
                end
                S_NORM:   r_cnt <= '0;
                S_SQ_ADJ: r_cnt <= r_cnt + 6'd1;
                S_LN:     r_log <= 24'(w_ln_prod[53:32]);
                S_ARM:    r_cnt <= '0;
                S_DIV_EXP, S_DIV_RAD, S_SQRT: begin
                    if (n_state != r_state) begin
                        r_cnt <= '0;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_SCORE: begin
                    if (!r_found || w_score > r_best_score) begin
                        r_best_score <= w_score;
                        r_best_arm   <= 10'(r_pos);
                        r_found      <= 1'b1;
                    end
                    r_pos <= r_pos + PW'(1);
                end
                S_DONE: begin
                    if (r_last && w_out_free) begin
                        r_in_run <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_succ  <= i_success_count;
            r_pulls <= i_pull_count;
            r_valid <= i_arm_valid;
            r_last  <= i_last_arm;
        end
        unique case (r_state)
            S_INC: begin
                if (r_total != 32'hFFFF_FFFF) begin
                    r_x <= {1'b0, r_total} + 33'd2;
                end else begin
                    r_x <= {1'b0, r_total} + 33'd1;
                end
                r_n <= 6'd32;
            end
            S_NORM: begin
                // Shift the argument up until its leading one is at the top.
                if (r_x[32]) begin
                    r_m    <= r_x[32:1];
                    r_frac <= '0;
                end else begin
                    r_x <= {r_x[31:0], 1'b0};
                    r_n <= r_n - 6'd1;
                end
            end
            S_SQ_MUL: r_prod <= 64'(r_m) * 64'(r_m);
            S_SQ_ADJ: begin
                // A squared mantissa at or above two yields a one bit.
                if (w_sq_top[32]) begin
                    r_m <= w_sq_top[32:1];
                end else begin
                    r_m <= w_sq_top[31:0];
                end
                r_frac <= {r_frac[14:0], w_sq_top[32]};
            end
            S_ARM: begin
                r_den <= {1'b0, r_pulls} + 33'd1;
                r_dq  <= {r_succ, 16'd0};
                r_rem <= '0;
            end
            S_DIV_EXP: begin
                if (r_cnt == EXP_LAST) begin
                    r_exploit <= w_exploit;
                    r_dq      <= {r_log, 24'd0};
                    r_rem     <= '0;
                end else begin
                    r_dq  <= w_quot;
                    r_rem <= w_sub.ge ? w_sub.diff : w_sub_a;
                end
            end
            S_DIV_RAD: begin
                if (r_cnt == RAD_LAST) begin
                    r_dq   <= {w_quot[39:0], 8'd0};
                    r_rem  <= '0;
                    r_root <= '0;
                end else begin
                    r_dq  <= w_quot;
                    r_rem <= w_sub.ge ? w_sub.diff : w_sub_a;
                end
            end
            S_SQRT: begin
                r_rem  <= w_sub.ge ? w_sub.diff : w_sub_a;
                r_root <= {r_root[18:0], w_sub.ge};
                r_dq   <= {r_dq[45:0], 2'b00};
            end
            S_EXPL: r_explore <= w_gain_prod[35:GAIN_FRAC];
            S_DONE: begin
                if (r_last && w_out_free) begin
                    r_out_index <= r_found ? r_best_arm : 10'd0;
                    r_out_found <= r_found;
                end
            end
            default: begin
            end
        endcase
    end

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= MAX_ARMS)
        else $error("arm position passed its limit");

    a_empty_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_pick_index == 10'd0))
        else $error("empty run reported a nonzero index");

    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !r_in_run) |=> (r_state == S_INC))
        else $error("new run did not update the total");

    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INC) |=> (r_total != 32'd0))
        else $error("selection total is zero inside a run");

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Regression for ucb1_arm_selector_core. Runs of arm items are queued and
// driven with random gaps. The result channel is stalled at random. Each
// accepted item is fed to a scoring predictor kept in this file. Every
// result is checked against the oldest predicted selection. The exploration
// gain is rewritten between phases, at its extremes among other values.
// ----------------------------------------------------------------------------
module testbench;
    import ucb1_pkg::*;

    typedef struct {
        logic [31:0] succ;
        logic [31:0] pulls;
        logic        valid;
        logic        last;
    } t_arm_item;

    typedef struct {
        logic [9:0] index;
        logic       found;
    } t_selection;

    localparam int ARM_LIMIT = 1024;
    localparam int DRAIN_CYCLES = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_success_count = '0;
    logic [31:0] i_pull_count = '0;
    logic        i_arm_valid = 1'b0;
    logic        i_last_arm = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [9:0]  o_pick_index;
    logic        o_found;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    ucb1_arm_selector_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_success_count(i_success_count), .i_pull_count(i_pull_count),
        .i_arm_valid(i_arm_valid), .i_last_arm(i_last_arm),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_pick_index(o_pick_index), .o_found(o_found),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_arm_item  arm_q[$];
    t_selection selection_q[$];
    int         errors = 0;

    // Predictor state.
    logic [15:0] gain = GAIN_RESET;
    logic [31:0] sel_total = '0;
    logic        run_open = 1'b0;
    logic [23:0] ln_total = '0;
    int          arm_pos = 0;
    logic [31:0] top_score = '0;
    logic [9:0]  top_arm = '0;
    logic        any_arm = 1'b0;

    function automatic longint unsigned log2_fx(longint unsigned x);
        longint unsigned n, m, res;
        n = 0;
        while ((x >> n) > 1) n++;
        m = (n >= 31) ? (x >> (n - 31)) : (x << (31 - n));
        res = n << FRAC_BITS;
        for (int i = FRAC_BITS - 1; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= (64'd2 << 31)) begin
                m = m >> 1;
                res = res | (64'd1 << i);
            end
        end
        return res;
    endfunction

    function automatic longint unsigned root_fx(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] ucb_score(logic [31:0] succ, logic [31:0] pulls);
        longint unsigned den, exploit, rad, explore, s;
        den = longint'(pulls) + 1;
        exploit = (longint'(succ) << FRAC_BITS) / den;
        if (exploit > longint'(EXPLOIT_CAP)) exploit = longint'(EXPLOIT_CAP);
        rad = (longint'(ln_total) << FRAC_BITS) / den;
        explore = (longint'(gain) * root_fx(rad)) >> GAIN_FRAC;
        s = exploit + explore;
        if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
        return s[31:0];
    endfunction

    task automatic select_step(t_arm_item it);
        longint unsigned lg;
        logic [31:0] s;
        t_selection sel;
        if (!run_open) begin
            if (sel_total != 32'hFFFF_FFFF) sel_total = sel_total + 1;
            lg = (log2_fx(longint'(sel_total) + 1) * longint'(LN2_Q32)) >> 32;
            if (lg > 64'hFF_FFFF) lg = 64'hFF_FFFF;
            ln_total = lg[23:0];
            run_open = 1'b1;
            arm_pos = 0;
            top_score = '0;
            top_arm = '0;
            any_arm = 1'b0;
        end
        if (it.valid && arm_pos < ARM_LIMIT) begin
            s = ucb_score(it.succ, it.pulls);
            if (!any_arm || s > top_score) begin
                top_score = s;
                top_arm = arm_pos[9:0];
                any_arm = 1'b1;
            end
            arm_pos++;
        end
        if (it.last) begin
            sel.index = any_arm ? top_arm : 10'd0;
            sel.found = any_arm;
            selection_q = {selection_q, sel};
            run_open = 1'b0;
        end
    endtask

    // Driver.
    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    int   in_gap = 0;
    int   stall_left = 0;
    logic calm_in = 1'b0;
    logic calm_out = 1'b0;

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (arm_q.size() > 0) begin
                t_arm_item it;
                it = arm_q.pop_front();
                i_success_count <= it.succ;
                i_pull_count <= it.pulls;
                i_arm_valid <= it.valid;
                i_last_arm <= it.last;
                i_in_valid <= 1'b1;
                if ($urandom_range(0, 63) == 0) calm_in = ~calm_in;
                in_gap <= calm_in ? 0 : $urandom_range(0, 19);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (out_taken) begin
            if ($urandom_range(0, 15) == 0) calm_out = ~calm_out;
            stall_left = calm_out ? 0 : $urandom_range(0, 19);
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_arm_item it;
        t_selection sel;
        in_taken <= i_in_valid && !o_in_stall;
        out_taken <= o_out_valid && !i_out_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            it.succ = i_success_count;
            it.pulls = i_pull_count;
            it.valid = i_arm_valid;
            it.last = i_last_arm;
            select_step(it);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (selection_q.size() == 0) begin
                $display("%0t: unexpected result index=%0d found=%0b", $time,
                         o_pick_index, o_found);
                errors++;
            end else begin
                sel = selection_q.pop_front();
                if (o_found !== sel.found) begin
                    $display("%0t: found expected %0b actual %0b", $time,
                             sel.found, o_found);
                    errors++;
                end
                if (o_pick_index !== sel.index) begin
                    $display("%0t: pick_index expected %0d actual %0d", $time,
                             sel.index, o_pick_index);
                    errors++;
                end
            end
        end
    end

    function automatic logic [31:0] pick_count();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 3);
            1: return $urandom_range(0, 40);
            2: return $urandom_range(0, 2000);
            3: return $urandom;
            4: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(0, 200000);
        endcase
    endfunction

    task automatic add_item(logic [31:0] succ, logic [31:0] pulls, logic valid,
                            logic last);
        t_arm_item it;
        it.succ = succ;
        it.pulls = pulls;
        it.valid = valid;
        it.last = last;
        arm_q = {arm_q, it};
    endtask

    task automatic add_runs(int n_items);
        int len;
        logic [31:0] p;
        while (n_items > 0) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                // Mostly plausible arms where success stays at or below the pulls.
                p = pick_count();
                if ($urandom_range(0, 3) != 0)
                    add_item((p == 0) ? 32'd0 : 32'($urandom % (longint'(p) + 1)), p,
                             $urandom_range(0, 7) != 0, k == len - 1);
                else
                    add_item(pick_count(), p, $urandom_range(0, 7) != 0, k == len - 1);
            end
            n_items -= len;
        end
    endtask

    task automatic settle();
        wait (arm_q.size() == 0 && !i_in_valid && selection_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gain(logic [15:0] g);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= g;
        do @(posedge i_clk); while (!o_cfg_ready);
        gain = g;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [15:0] gains[5];
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed runs.
        add_item(32'd5, 32'd5, 1'b0, 1'b1);              // no valid arm at all
        add_item(32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0);      // saturated exploitation
        add_item(32'd0, 32'd0, 1'b1, 1'b0);
        add_item(32'd0, 32'hFFFF_FFFF, 1'b1, 1'b0);
        add_item(32'd7, 32'd1, 1'b0, 1'b0);              // skipped item
        add_item(32'hFFFF_FFFF, 32'd0, 1'b1, 1'b1);      // ties the first arm
        add_item(32'd3, 32'd9, 1'b1, 1'b1);              // single arm run
        add_item(32'd0, 32'd0, 1'b1, 1'b0);
        add_item(32'd0, 32'd0, 1'b1, 1'b0);
        add_item(32'd1, 32'd0, 1'b1, 1'b1);              // later arm wins
        add_item(32'd1, 32'd2, 1'b0, 1'b0);
        add_item(32'd2, 32'd3, 1'b0, 1'b1);              // invalid run of two
        add_item(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0);
        add_item(32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0);
        add_item(32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b1);
        add_runs(40);
        settle();

        gains = '{16'd0, 16'hFFFF, 16'd1, 16'd16384, 16'd0};
        gains[4] = 16'($urandom);
        foreach (gains[g]) begin
            write_gain(gains[g]);
            if (g == 2) begin
                // More valid arms than the block can rank.
                for (int k = 0; k < ARM_LIMIT + 6; k++)
                    add_item($urandom_range(0, 100), $urandom_range(0, 100),
                             1'b1, k == ARM_LIMIT + 5);
            end else begin
                add_runs(15);
            end
            settle();
        end
        write_gain(GAIN_RESET);
        add_runs(10);
        settle();

        if (errors == 0)
            $display("ucb1_arm_selector_core regression: pass");
        else
            $display("ucb1_arm_selector_core regression: fail");
        $finish;
    end

    initial begin
        #60_000_000;
        $display("ucb1_arm_selector_core regression: fail");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/ucb1_pkg.sv
hw/rtl/ucb1_sub_unit.sv
hw/rtl/ucb1_arm_selector_core.sv
test/testbench.sv
